// ===== rtl/core/sdf_pkg.sv =====
// Shared types and constants for the stream duplicate filter.
package sdf_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    start_req;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_res;
        logic                    overflow;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch input item, clear table on start_req
        logic scan;   // issue next table read
        logic emit;   // load result register, store value if room
    } t_sdf_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;       // returned entry equals current value
        logic done;      // all entries read and compared
        logic out_free;  // result register can take an item this cycle
    } t_sdf_sts;

endpackage

// ===== rtl/core/sdf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sdf_ctrl.sv =====
// Control state machine of the stream duplicate filter.
module sdf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sdf_pkg::t_sdf_sts i_sts,
    output sdf_pkg::t_sdf_cmd o_cmd
);
    import sdf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = ST_IDLE;      // duplicate: drop
                end else if (i_sts.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/sdf_dp.sv =====
// Datapath: value register, seen table, scan pointer and result register.
module sdf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdf_pkg::t_in_item  i_data,
    input  sdf_pkg::t_sdf_cmd  i_cmd,
    output sdf_pkg::t_sdf_sts  o_sts,
    output logic               o_valid,
    input  logic               i_ready,
    output sdf_pkg::t_out_item o_data
);
    import sdf_pkg::*;

    logic signed [VAL_W-1:0] r_val;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        n_idx;
    logic                    r_rd_vld;
    logic                    n_rd_vld;
    logic                    r_out_vld;
    logic                    n_out_vld;
    t_out_item               r_out;
    logic                    issue;
    logic                    room;
    logic                    wr_en;
    logic [VAL_W-1:0]        rd_data;

    assign issue = i_cmd.scan && (r_idx < r_count);
    assign room  = r_count < CNT_W'(TABLE_DEPTH);
    assign wr_en = i_cmd.emit && room;

    sdf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ($unsigned(r_val)),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign o_sts.hit      = r_rd_vld && (rd_data == $unsigned(r_val));
    assign o_sts.done     = (r_idx == r_count) && !r_rd_vld;
    assign o_sts.out_free = !r_out_vld || i_ready;

    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_vld  = r_rd_vld;
        n_out_vld = r_out_vld;
        if (i_ready) begin
            n_out_vld = 1'b0;
        end
        if (i_cmd.load) begin
            n_idx    = '0;
            n_rd_vld = 1'b0;
            if (i_data.start_req) begin
                n_count = '0;
            end
        end else if (i_cmd.scan) begin
            n_rd_vld = issue;
            if (issue) begin
                n_idx = r_idx + CNT_W'(1);
            end
        end
        if (i_cmd.emit) begin
            n_out_vld = 1'b1;
            if (room) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_data.value;
        end
        if (i_cmd.emit) begin
            r_out.value_res <= r_val;
            r_out.overflow  <= !room;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("seen count beyond table depth");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("scan pointer past seen count");

    a_rd_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_idx != '0))
        else $error("read data flagged without an issued read");

    a_no_emit_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> !$past(i_cmd.emit))
        else $error("result register overwritten while stalled");

endmodule

// ===== rtl/core/stream_duplicate_filter_unit.sv =====
// Top level of the stream duplicate filter: controller plus datapath.
//
// Passes on each signed 32-bit value only the first time it appears since
// the last start mark (while the table has room). Both channels are
// valid/ready; an item moves on an edge where valid and ready are both high.
//   Input item : value, start_req (start_req clears the seen table first).
//   Result item: value_res, overflow (table full, value not stored).
// Duplicates produce no result.
// Timing: one item is handled at a time. After acceptance the table is
// read one entry per cycle through the RAM's registered read port until
// all stored entries are compared; a duplicate ends the scan at the
// matching entry. The next item is taken once the previous one has been
// placed in the result register or dropped.
// Stall: the result register holds its item until taken; input is still
// accepted meanwhile, and a new result waits in its final state.
// Reset: synchronous, active low; clears the count, so the table reads as
// empty; table contents are left as they are.
module stream_duplicate_filter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sdf_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output sdf_pkg::t_out_item o_data
);
    import sdf_pkg::*;

    t_sdf_cmd cmd;
    t_sdf_sts sts;

    sdf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sdf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// ===== bench/stream_duplicate_filter_unit_tb.sv =====
// Self-checking bench for the stream duplicate filter: random valid/ready traffic vs. a predictor.
module stream_duplicate_filter_unit_tb;
    import sdf_pkg::*;

    // Tracks which values were already passed on in the current list and
    // keeps the first occurrences still owed by the block, oldest first.
    class first_seen_tracker;
        logic signed [VAL_W-1:0] seen_vals[TABLE_DEPTH];
        int unsigned             seen_cnt;
        t_out_item               due_firsts[$];
        int unsigned             mismatch_count;

        function new();
            seen_cnt       = 0;
            mismatch_count = 0;
        endfunction

        // Accepted input item: queue its result if it is a first occurrence.
        function void note_value(t_in_item it);
            t_out_item first;
            bit        found;
            found = 1'b0;
            if (it.start_req) seen_cnt = 0;
            for (int k = 0; k < seen_cnt; k++) begin
                if (seen_vals[k] == it.value) found = 1'b1;
            end
            if (found) return;
            first.value_res = it.value;
            first.overflow  = (seen_cnt >= TABLE_DEPTH);
            // full table: value still goes out, but is not remembered
            if (!first.overflow) begin
                seen_vals[seen_cnt] = it.value;
                seen_cnt++;
            end
            due_firsts.push_back(first);
        endfunction

        // Accepted result item: compare with the oldest owed result.
        function void check_emit(t_out_item got);
            t_out_item want;
            if (due_firsts.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item: expected none, actual value_res=%0d overflow=%0b",
                         $time, got.value_res, got.overflow);
                return;
            end
            want = due_firsts.pop_front();
            if (got.value_res !== want.value_res) begin
                mismatch_count++;
                $display("%0t: value_res mismatch: expected %0d, actual %0d",
                         $time, want.value_res, got.value_res);
            end
            if (got.overflow !== want.overflow) begin
                mismatch_count++;
                $display("%0t: overflow mismatch for %0d: expected %0b, actual %0b",
                         $time, want.value_res, want.overflow, got.overflow);
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    t_in_item          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_data;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                items_sent     = 0;
    first_seen_tracker tracker;

    stream_duplicate_filter_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Offer one item, with random idle cycles ahead of it, and hold it until taken.
    task automatic push_item(input logic signed [VAL_W-1:0] v, input bit s);
        t_in_item it;
        it.value     = v;
        it.start_req = s;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_value(it);
        items_sent++;
    endtask

    // Mostly full-range random, sometimes near zero or near either extreme.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return $urandom_range(8) - 4;
            1:       return {1'b1, {(VAL_W-1){1'b0}}} + $urandom_range(3);
            2:       return {1'b0, {(VAL_W-1){1'b1}}} - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // Short list drawn from a small pool, so repeats are common.
    // Usually opens with a start mark; a few stray marks land mid-list.
    task automatic send_short_list();
        logic signed [VAL_W-1:0] pool[$];
        int                      len;
        int                      pool_n;
        len    = $urandom_range(40, 1);
        pool_n = $urandom_range(len, 1);
        for (int k = 0; k < pool_n; k++) pool.push_back(pick_value());
        for (int k = 0; k < len; k++) begin
            push_item(pool[$urandom_range(pool_n - 1)],
                      (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(99) < 3));
        end
    endtask

    // Fills the whole table, then mixes stored repeats, new values that spill
    // (overflow) and repeats of spilled values (overflow again).
    task automatic send_fill_list();
        logic signed [VAL_W-1:0] kept[$];
        logic signed [VAL_W-1:0] spilled[$];
        logic signed [VAL_W-1:0] v;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            v = $urandom;
            push_item(v, k == 0);
            kept.push_back(v);
            if ($urandom_range(9) == 0) push_item(kept[$urandom_range(k)], 1'b0);
        end
        for (int k = 0; k < 60; k++) begin
            case ($urandom_range(2))
                0: push_item(kept[$urandom_range(TABLE_DEPTH - 1)], 1'b0);
                1: begin
                    v = $urandom;
                    push_item(v, 1'b0);
                    spilled.push_back(v);
                end
                default: begin
                    if (spilled.size() != 0) begin
                        push_item(spilled[$urandom_range(spilled.size() - 1)], 1'b0);
                    end else begin
                        v = $urandom;
                        push_item(v, 1'b0);
                        spilled.push_back(v);
                    end
                end
            endcase
        end
    endtask

    task automatic run_phase(input int n, input bit with_fill);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at - (3 * n) / 4) send_short_list();
        if (with_fill) send_fill_list();
        while (items_sent < stop_at) send_short_list();
    endtask

    // Result side: take items as they come, stalling at random.
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) tracker.check_emit(out_data);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: start mark on empty table, extremes, repeats, restarts
        push_item(32'sh0000_0000, 1'b1);
        push_item(32'sh0000_0000, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'shFFFF_FFFF, 1'b0);
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item(32'sh0000_0001, 1'b0);
        push_item(32'shFFFF_FFFF, 1'b0);
        push_item(32'sh5555_5555, 1'b0);
        push_item(32'shAAAA_AAAA, 1'b0);
        push_item(32'sh5555_5555, 1'b0);
        push_item(32'shFFFF_FFFF, 1'b1);
        push_item(32'sh0000_0000, 1'b0);
        push_item(32'sh0000_0000, 1'b1);
        push_item(32'sh0000_0000, 1'b1);
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'sh8000_0000, 1'b0);

        send_idle_pct  = 24;
        recv_stall_pct = 86;
        run_phase(420, 1'b1);
        send_idle_pct  = 86;
        recv_stall_pct = 24;
        run_phase(380, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_phase(420, 1'b1);
        in_valid <= 1'b0;

        while (tracker.due_firsts.size() != 0) @(posedge clk);
        // a full-table scan plus margin, to catch any stray result
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (tracker.mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sdf_pkg.sv
rtl/core/sdf_ram.sv
rtl/core/sdf_ctrl.sv
rtl/core/sdf_dp.sv
rtl/core/stream_duplicate_filter_unit.sv
bench/stream_duplicate_filter_unit_tb.sv
